@@ rtl/b64bc_pkg.sv @@
// Shared types, status codes and alphabet functions of the base64 block codec.
`timescale 1ns / 1ps

package b64bc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SYMBOL = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } status_e;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } out_item_t;

  // Results caused by one request: up to four items, entry 0 goes out first
  typedef struct packed {
    logic [2:0]      count;
    out_item_t [3:0] items;
  } out_group_t;

  // Decoded symbol: six-bit value and an in-alphabet flag
  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sym_t;

  // Map a six-bit value to its ASCII symbol
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] wide;
    logic [7:0] ch;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      ch = wide + 8'd65;          // 'A'
    end else if (idx < 6'd52) begin
      ch = wide + 8'd71;          // 'a' - 26
    end else if (idx < 6'd62) begin
      ch = wide - 8'd4;           // '0' is 52 - 4
    end else if (idx == 6'd62) begin
      ch = 8'h2B;                 // '+'
    end else begin
      ch = 8'h2F;                 // '/'
    end
    return ch;
  endfunction

  // Map an ASCII symbol to its six-bit value, flag symbols outside the alphabet
  function automatic sym_t b64_value(input logic [7:0] c);
    sym_t       s;
    logic [7:0] v;
    s.ok = 1'b1;
    v    = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      v = c - 8'd65;
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = c - 8'd71;
    end else if (c inside {[8'h30:8'h39]}) begin
      v = c + 8'd4;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      s.ok = 1'b0;
    end
    s.value = v[5:0];
    return s;
  endfunction

endpackage

@@ rtl/b64bc_out_buf.sv @@
// Result buffer: holds a request's results; sends one per cycle unless stalled.
`timescale 1ns / 1ps

module b64bc_out_buf
  import b64bc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  out_group_t group_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o,
  output logic [1:0] status_o,
  output logic       last_out_o
);

  logic [2:0]      cnt_q, cnt_d;
  out_item_t [3:0] items_q, items_d;
  logic            pop;

  assign pop = (cnt_q != 3'd0) && out_ready_i;

  // Free when empty or when the last held result leaves this cycle
  assign free_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);

  // Shift out on pop, overwrite on load
  always_comb begin
    cnt_d   = cnt_q;
    items_d = items_q;
    if (pop) begin
      items_d[2:0] = items_q[3:1];
      items_d[3]   = '0;
      cnt_d        = cnt_q - 3'd1;
    end
    if (load_i) begin
      items_d = group_i.items;
      cnt_d   = group_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    items_q <= items_d;
  end

  // Drive the head entry
  assign out_valid_o = (cnt_q != 3'd0);
  assign data_out_o  = items_q[0].data;
  assign status_o    = items_q[0].status;
  assign last_out_o  = items_q[0].last;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result buffer loaded while still holding results");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result buffer count out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cnt_q == 3'd1) && !load_i) |=> (cnt_q == 3'd0))
    else $error("result buffer did not empty after last pop");
`endif

endmodule

@@ rtl/base64_block_codec.sv @@
// Top level of the streaming base64 block codec (standard alphabet, no padding).
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------
//  input   | in_valid_i / in_ready_o      | data_in_i[7:0], last_in_i
//  output  | out_valid_o / out_ready_i    | data_out_o[7:0], status_o[1:0], last_out_o
//  config  | cfg_we_i (no wait)           | cfg_wdata_i (decode_mode)
//
// A request is processed in the cycle it is accepted; its results appear in the next cycle.
// Results leave one per cycle while out_ready_i is high, from a four-entry buffer; a new
// request is taken while the buffer is empty or sending its last entry.
// Reset and a config write clear all block state; no clearing pass is needed.
// A stalled output holds the buffer and, while it holds any result, the input.
`timescale 1ns / 1ps

module base64_block_codec
  import b64bc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_in_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o,
  output logic [1:0] status_o,
  output logic       last_out_o
);

  localparam int unsigned GROUPS = BLOCK_BYTES / 3;
  localparam int unsigned CW     = $clog2(4 * GROUPS + 2);
  localparam logic [CW-1:0] LEN_ENC = CW'(3 * GROUPS);
  localparam logic [CW-1:0] LEN_DEC = CW'(4 * GROUPS);

  logic          mode_q, mode_d;
  logic [23:0]   bits_q, bits_d;
  logic [1:0]    fill_q, fill_d;
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;

  logic          accept;
  logic          buf_free;
  logic          load;
  logic [CW-1:0] len;
  sym_t          sym;
  status_e       err;
  logic [2:0]    n;
  out_group_t    grp;

  assign in_ready_o = buf_free;
  assign accept     = in_valid_i && buf_free;
  assign len        = mode_q ? LEN_DEC : LEN_ENC;
  assign sym        = b64_value(data_in_i);

  // Update block state and build the results of the accepted request
  always_comb begin
    mode_d  = mode_q;
    bits_d  = bits_q;
    fill_d  = fill_q;
    count_d = count_q;
    drop_d  = drop_q;
    grp     = '0;
    n       = 3'd0;
    err     = ST_OK;
    if (accept) begin
      if (!drop_q && (count_q < len)) begin
        count_d = count_q + 1'b1;
        if (!mode_q) begin
          // Encode: gather three bytes, emit four symbols
          bits_d = {bits_q[15:0], data_in_i};
          if (fill_q == 2'd2) begin
            grp.items[0].data = b64_char(bits_d[23:18]);
            grp.items[1].data = b64_char(bits_d[17:12]);
            grp.items[2].data = b64_char(bits_d[11:6]);
            grp.items[3].data = b64_char(bits_d[5:0]);
            n      = 3'd4;
            bits_d = '0;
            fill_d = 2'd0;
          end else begin
            fill_d = fill_q + 2'd1;
          end
        end else if (!sym.ok) begin
          // Drop the rest of the block after a bad symbol
          drop_d = 1'b1;
        end else begin
          // Decode: gather four symbols, emit three bytes
          bits_d = {bits_q[17:0], sym.value};
          if (fill_q == 2'd3) begin
            grp.items[0].data = bits_d[23:16];
            grp.items[1].data = bits_d[15:8];
            grp.items[2].data = bits_d[7:0];
            n      = 3'd3;
            bits_d = '0;
            fill_d = 2'd0;
          end else begin
            fill_d = fill_q + 2'd1;
          end
        end
      end else if (!drop_q) begin
        // Saturate one above the expected length
        count_d = len + 1'b1;
      end

      if (last_in_i) begin
        if (drop_d) begin
          err = ST_BAD_SYMBOL;
        end else if ((count_d != len) || (fill_d != 2'd0)) begin
          err = ST_BAD_LENGTH;
        end
        // Replace the results by a single error result
        if ((err != ST_OK) || (n == 3'd0)) begin
          grp.items           = '0;
          grp.items[0].status = (err == ST_OK) ? ST_BAD_LENGTH : err;
          n                   = 3'd1;
        end
        grp.items[2'(n - 3'd1)].last = 1'b1;
        bits_d  = '0;
        fill_d  = 2'd0;
        count_d = '0;
        drop_d  = 1'b0;
      end
    end

    // A mode write clears the block
    if (cfg_we_i) begin
      mode_d  = cfg_wdata_i;
      bits_d  = '0;
      fill_d  = 2'd0;
      count_d = '0;
      drop_d  = 1'b0;
    end
    grp.count = n;
  end

  assign load = accept && (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      bits_q  <= '0;
      fill_q  <= 2'd0;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      bits_q  <= bits_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  b64bc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .group_i     (grp),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .last_out_o  (last_out_o)
  );

`ifndef NO_ASSERTIONS
  a_block_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_in_i && !cfg_we_i) |=>
      ((count_q == '0) && (fill_q == 2'd0) && !drop_q && (bits_q == '0)))
    else $error("block state not cleared after last request");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_in_i) |=> out_valid_o)
    else $error("last request gave no result");

  a_enc_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> (fill_q != 2'd3))
    else $error("encode group fill out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (len + 1'b1))
    else $error("item count beyond saturation");
`endif

endmodule

@@ tb/base64_block_codec_test.sv @@
// Self-checking testbench for the streaming base64 block codec.
`timescale 1ns / 1ps

module base64_block_codec_test
  import b64bc_pkg::*;
;

  localparam int unsigned BLOCK_BYTES = 48;
  localparam int unsigned GROUPS      = BLOCK_BYTES / 3;
  localparam int unsigned ITEM_BUDGET = 280;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_AT     = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef enum {
    BLK_GOOD,
    BLK_SHORT,
    BLK_LONG,
    BLK_BAD_SYMBOL,
    BLK_ABANDON
  } block_kind_e;

  // Tracks block state and the coded results the codec still owes
  class codec_tracker;
    int unsigned groups;
    bit          decode_mode;
    logic [23:0] group_bits;
    int unsigned group_fill;
    int unsigned item_count;
    bit          drop_flag;
    string       symbols;
    out_item_t   owed_q[$];
    int unsigned errors;

    function new(int unsigned n_groups);
      groups      = n_groups;
      symbols     = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      decode_mode = 1'b0;
      errors      = 0;
      clear_block();
    endfunction

    function void clear_block();
      group_bits = '0;
      group_fill = 0;
      item_count = 0;
      drop_flag  = 1'b0;
    endfunction

    function void set_mode(bit m);
      decode_mode = m;
      clear_block();
    endfunction

    // Six-bit value of an ASCII symbol, -1 outside the alphabet
    function int index_of(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (symbols[i] == c) begin
          return i;
        end
      end
      return -1;
    endfunction

    function logic [7:0] symbol_of(logic [5:0] idx);
      return symbols[idx];
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance block state for one accepted request and queue its results
    function void take_request(logic [7:0] d, logic is_last);
      out_item_t   step_q[$];
      out_item_t   r;
      int          v;
      int unsigned len;
      status_e     st;
      len      = decode_mode ? 4 * groups : 3 * groups;
      r.data   = '0;
      r.status = ST_OK;
      r.last   = 1'b0;
      if (!drop_flag && item_count < len) begin
        item_count++;
        if (!decode_mode) begin
          group_bits = {group_bits[15:0], d};
          group_fill++;
          if (group_fill == 3) begin
            for (int k = 3; k >= 0; k--) begin
              r.data = symbol_of(group_bits[6*k +: 6]);
              step_q.push_back(r);
            end
            group_bits = '0;
            group_fill = 0;
          end
        end else begin
          v = index_of(d);
          if (v < 0) begin
            drop_flag = 1'b1;
          end else begin
            group_bits = {group_bits[17:0], 6'(v)};
            group_fill++;
            if (group_fill == 4) begin
              for (int k = 2; k >= 0; k--) begin
                r.data = group_bits[8*k +: 8];
                step_q.push_back(r);
              end
              group_bits = '0;
              group_fill = 0;
            end
          end
        end
      end else if (!drop_flag) begin
        item_count = len + 1;
      end
      // Close the block: an error replaces whatever this request produced
      if (is_last) begin
        st = ST_OK;
        if (drop_flag) begin
          st = ST_BAD_SYMBOL;
        end else if (item_count != len || group_fill != 0) begin
          st = ST_BAD_LENGTH;
        end
        if (st != ST_OK || step_q.size() == 0) begin
          step_q.delete();
          r.data   = '0;
          r.status = (st == ST_OK) ? ST_BAD_LENGTH : st;
          step_q.push_back(r);
        end
        r      = step_q.pop_back();
        r.last = 1'b1;
        step_q.push_back(r);
        clear_block();
      end
      foreach (step_q[i]) begin
        owed_q.push_back(step_q[i]);
      end
    endfunction

    // Compare one accepted result with the oldest owed one
    function void match_result(logic [7:0] d, logic [1:0] st, logic is_last);
      out_item_t want;
      out_item_t got;
      got.data   = d;
      got.status = status_e'(st);
      got.last   = is_last;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: data %02h status %0d last %0d",
                 $time, d, st, is_last);
      end else begin
        want = owed_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: want %02h/%0d/%0d got %02h/%0d/%0d (data/status/last)",
                   $time, want.data, want.status, want.last,
                   got.data, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_in_i;
  logic       last_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_out_o;
  logic [1:0] status_o;
  logic       last_out_o;

  codec_tracker tracker;
  bit           calm;
  bit           cur_mode;
  bit           pause_pending;
  int unsigned  items_used;
  int unsigned  results_taken;

  base64_block_codec #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_in_i  (data_in_i),
    .last_in_i  (last_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .last_out_o (last_out_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample handshakes and config writes at each rising edge
  always @(posedge clk_i) begin
    if (rst_ni && tracker != null) begin
      if (cfg_we_i) begin
        tracker.set_mode(cfg_wdata_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.match_result(data_out_o, status_o, last_out_o);
      end
      if (in_valid_i && in_ready_o) begin
        tracker.take_request(data_in_i, last_in_i);
      end
    end
  end

  // End the run when no handshake completes for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall before each result, one long hold to back up the input
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (results_taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_item(input logic [7:0] d, input logic is_last);
    int unsigned gap;
    items_used++;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_in_i  <= d;
    last_in_i  <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_requests();
    in_valid_i <= 1'b0;
  endtask

  // Wait until every owed result has come out
  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Write decode_mode once the codec is idle
  task automatic write_mode(input logic m);
    stop_requests();
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [7:0] pick_symbol();
    return tracker.symbol_of(6'($urandom_range(0, 63)));
  endfunction

  function automatic logic [7:0] pick_bad();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (tracker.index_of(c) >= 0);
    return c;
  endfunction

  // Send one block of the given kind in the current mode
  task automatic run_block(input block_kind_e kind);
    int unsigned len;
    int unsigned n;
    int unsigned bad_at;
    logic [7:0]  d;
    len    = cur_mode ? 4 * GROUPS : 3 * GROUPS;
    n      = len;
    bad_at = 0;
    case (kind)
      BLK_SHORT, BLK_ABANDON: begin
        n = $urandom_range(1, len - 1);
      end
      BLK_LONG: begin
        n = len + $urandom_range(1, 6);
      end
      BLK_BAD_SYMBOL: begin
        case ($urandom_range(0, 2))
          0: n = len;
          1: n = $urandom_range(1, len - 1);
          default: n = len + $urandom_range(1, 6);
        endcase
        bad_at = $urandom_range(0, ((n < len) ? n : len) - 1);
      end
      default: begin
        n = len;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (!cur_mode) begin
        d = 8'($urandom_range(0, 255));
      end else if (kind == BLK_BAD_SYMBOL && i == bad_at) begin
        d = pick_bad();
      end else begin
        d = pick_symbol();
      end
      send_item(d, (kind != BLK_ABANDON) && (i == n - 1));
      // Hold the sender once in mid-block until the output has drained
      if (pause_pending && kind == BLK_GOOD && i == len / 2) begin
        stop_requests();
        wait_drained();
        pause_pending = 1'b0;
      end
    end
    // Drop a half-sent block by rewriting the mode
    if (kind == BLK_ABANDON) begin
      write_mode(1'($urandom_range(0, 1)));
    end
  endtask

  // Main sequence
  initial begin
    block_kind_e kind;
    tracker       = new(GROUPS);
    calm          = 1'b0;
    cur_mode      = 1'b0;
    pause_pending = 1'b1;
    items_used    = 0;
    results_taken = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    data_in_i   <= '0;
    last_in_i   <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Encode: full group cut short, partial group, single byte
    write_mode(1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h55, 1'b1);

    // Decode: alphabet edges in a short block, then bad symbols
    write_mode(1'b1);
    send_item("A", 1'b0);
    send_item("/", 1'b0);
    send_item("+", 1'b0);
    send_item("z", 1'b0);
    send_item("0", 1'b0);
    send_item("9", 1'b0);
    send_item("Z", 1'b0);
    send_item("a", 1'b1);
    send_item("=", 1'b0);
    send_item("A", 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item("Q", 1'b0);
    send_item("=", 1'b1);

    // Random blocks, one well-formed block of each mode first
    write_mode(1'b0);
    run_block(BLK_GOOD);
    write_mode(1'b1);
    run_block(BLK_GOOD);
    while (items_used < ITEM_BUDGET) begin
      if ($urandom_range(0, 2) == 0) begin
        write_mode(~cur_mode);
      end
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: kind = BLK_GOOD;
        5:             kind = BLK_SHORT;
        6:             kind = BLK_LONG;
        7, 8:          kind = cur_mode ? BLK_BAD_SYMBOL : BLK_LONG;
        default:       kind = BLK_ABANDON;
      endcase
      run_block(kind);
    end

    // Drain and let any stray result show up
    calm = 1'b0;
    stop_requests();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ base64_block_codec.f @@
rtl/b64bc_pkg.sv
rtl/b64bc_out_buf.sv
rtl/base64_block_codec.sv
tb/base64_block_codec_test.sv
